// ----- rtl/mtep_pkg.sv -----
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared types and codes for the track-chunk event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned LEN_W  = 28;

   // result kinds
   localparam logic [2:0] KIND_CHANNEL = 3'd0;
   localparam logic [2:0] KIND_SYSEX   = 3'd1;
   localparam logic [2:0] KIND_META    = 3'd2;
   localparam logic [2:0] KIND_PAYLOAD = 3'd3;
   localparam logic [2:0] KIND_END     = 3'd4;
   localparam logic [2:0] KIND_ERROR   = 3'd5;

   // status and meta codes
   localparam logic [7:0] STATUS_SYSEX      = 8'hF0;
   localparam logic [7:0] STATUS_META       = 8'hFF;
   localparam logic [7:0] META_END_OF_TRACK = 8'h2F;
   localparam logic [7:0] META_MTC_OFFSET   = 8'h54;
   localparam logic [3:0] HIGH_KEY_ON       = 4'h9;
   localparam logic [3:0] HIGH_KEY_OFF      = 4'h8;

   typedef enum logic [7:0] {
      PH_DELTA     = 8'b0000_0001,
      PH_STATUS    = 8'b0000_0010,
      PH_DATA1     = 8'b0000_0100,
      PH_DATA2     = 8'b0000_1000,
      PH_META_TYPE = 8'b0001_0000,
      PH_SYSEX_LEN = 8'b0010_0000,
      PH_META_LEN  = 8'b0100_0000,
      PH_PAYLOAD   = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] track_byte;
      logic       chunk_last;
   } item_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [TIME_W-1:0] event_time;
      logic [7:0]        status_byte;
      logic [7:0]        data_one;
      logic [7:0]        data_two;
      logic [LEN_W-1:0]  payload_length;
      logic              last_of_event;
   } result_type;

endpackage

// ----- rtl/mtep_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one track-chunk byte per word.
// ----------------------------------------------------------------------------
interface mtep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] track_byte;
   logic       chunk_last;

   modport source (output valid, output track_byte, output chunk_last, input ready);
   modport sink   (input valid, input track_byte, input chunk_last, output ready);
endinterface

// ----- rtl/mtep_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one decoded event result per word.
// ----------------------------------------------------------------------------
interface mtep_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [2:0]                 kind;
   logic [mtep_pkg::TIME_W-1:0] event_time;
   logic [7:0]                 status_byte;
   logic [7:0]                 data_one;
   logic [7:0]                 data_two;
   logic [mtep_pkg::LEN_W-1:0] payload_length;
   logic                       last_of_event;

   modport source (output valid, output kind, output event_time, output status_byte,
                   output data_one, output data_two, output payload_length,
                   output last_of_event, input ready);
   modport sink   (input valid, input kind, input event_time, input status_byte,
                   input data_one, input data_two, input payload_length,
                   input last_of_event, output ready);
endinterface

// ----- rtl/mtep_in_reg.sv -----
// ----------------------------------------------------------------------------
// Input register
// Holds one incoming word until the decoder takes it.
// ----------------------------------------------------------------------------
module mtep_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  mtep_pkg::item_type load_item,
   input  logic               advance,
   output logic               hold_valid,
   output mtep_pkg::item_type hold_item
);

   logic               valid_ff, valid_in;
   mtep_pkg::item_type item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

endmodule

// ----- rtl/mtep_decoder.sv -----
// ----------------------------------------------------------------------------
// Event decoder
// Parse state and the combinational phase update for one track byte.
// ----------------------------------------------------------------------------
module mtep_decoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  mtep_pkg::item_type   item,
   output logic                 res_valid,
   output mtep_pkg::result_type res
);

   mtep_pkg::phase_type               phase_ff, phase_in;
   logic [7:0]                        running_status_ff, running_status_in;
   logic [mtep_pkg::TIME_W-1:0]       clock_ff, clock_in;
   logic [31:0]                       varlen_ff, varlen_in;
   logic [mtep_pkg::LEN_W-1:0]        remaining_ff, remaining_in;
   logic [7:0]                        current_type_ff, current_type_in;
   logic [7:0]                        held_data_ff, held_data_in;
   logic                              done_ff, done_in;

   logic [7:0]                        b;
   logic [31:0]                       acc;
   logic [mtep_pkg::LEN_W-1:0]        len;
   logic                              varlen_end;

   function automatic logic [1:0] data_count(input logic [7:0] st);
      case (st[7:4])
         4'h8, 4'h9, 4'hA, 4'hB, 4'hE: data_count = 2'd2;
         4'hC, 4'hD:                   data_count = 2'd1;
         default:                      data_count = 2'd0;
      endcase
   endfunction

   assign b          = item.track_byte;
   assign acc        = {varlen_ff[24:0], b[6:0]};
   assign len        = acc[mtep_pkg::LEN_W-1:0];
   assign varlen_end = ~b[7];

   always_comb begin
      phase_in          = phase_ff;
      running_status_in = running_status_ff;
      clock_in          = clock_ff;
      varlen_in         = varlen_ff;
      remaining_in      = remaining_ff;
      current_type_in   = current_type_ff;
      held_data_in      = held_data_ff;
      done_in           = done_ff;

      res_valid          = 1'b0;
      res.kind           = mtep_pkg::KIND_CHANNEL;
      res.event_time     = clock_ff;
      res.status_byte    = 8'd0;
      res.data_one       = 8'd0;
      res.data_two       = 8'd0;
      res.payload_length = '0;
      res.last_of_event  = 1'b1;

      if (!done_ff) begin
         case (phase_ff)
            mtep_pkg::PH_STATUS, mtep_pkg::PH_DATA1: begin
               if (phase_ff == mtep_pkg::PH_STATUS && b == mtep_pkg::STATUS_SYSEX) begin
                  current_type_in = mtep_pkg::STATUS_SYSEX;
                  varlen_in       = '0;
                  phase_in        = mtep_pkg::PH_SYSEX_LEN;
               end else if (phase_ff == mtep_pkg::PH_STATUS &&
                            b == mtep_pkg::STATUS_META) begin
                  phase_in = mtep_pkg::PH_META_TYPE;
               end else if (phase_ff == mtep_pkg::PH_STATUS && b[7]) begin
                  running_status_in = b;
                  if (data_count(b) == 2'd0) begin
                     res_valid       = 1'b1;
                     res.kind        = mtep_pkg::KIND_ERROR;
                     res.status_byte = b;
                     done_in         = 1'b1;
                     phase_in        = mtep_pkg::PH_DELTA;
                  end else begin
                     phase_in = mtep_pkg::PH_DATA1;
                  end
               end else begin
                  // first data byte under the current running status
                  res.status_byte = running_status_ff;
                  if (data_count(running_status_ff) == 2'd0) begin
                     res_valid = 1'b1;
                     res.kind  = mtep_pkg::KIND_ERROR;
                     done_in   = 1'b1;
                     phase_in  = mtep_pkg::PH_DELTA;
                  end else begin
                     held_data_in = b;
                     if (data_count(running_status_ff) == 2'd1) begin
                        res_valid    = 1'b1;
                        res.data_one = b;
                        phase_in     = mtep_pkg::PH_DELTA;
                     end else begin
                        phase_in = mtep_pkg::PH_DATA2;
                     end
                  end
               end
            end
            mtep_pkg::PH_DATA2: begin
               res_valid       = 1'b1;
               res.status_byte = running_status_ff;
               res.data_one    = held_data_ff;
               res.data_two    = b;
               // key-on with zero velocity goes out as key-off
               if (running_status_ff[7:4] == mtep_pkg::HIGH_KEY_ON && b == 8'd0) begin
                  res.status_byte = {mtep_pkg::HIGH_KEY_OFF, running_status_ff[3:0]};
               end
               phase_in = mtep_pkg::PH_DELTA;
            end
            mtep_pkg::PH_META_TYPE: begin
               current_type_in = b;
               varlen_in       = '0;
               phase_in        = mtep_pkg::PH_META_LEN;
            end
            mtep_pkg::PH_SYSEX_LEN, mtep_pkg::PH_META_LEN: begin
               if (!varlen_end) begin
                  varlen_in = acc;
               end else begin
                  varlen_in          = '0;
                  res_valid          = 1'b1;
                  res.payload_length = len;
                  if (phase_ff == mtep_pkg::PH_META_LEN &&
                      current_type_ff == mtep_pkg::META_END_OF_TRACK) begin
                     res.kind        = mtep_pkg::KIND_END;
                     res.status_byte = mtep_pkg::META_END_OF_TRACK;
                     done_in         = 1'b1;
                     phase_in        = mtep_pkg::PH_DELTA;
                  end else begin
                     if (phase_ff == mtep_pkg::PH_META_LEN &&
                         current_type_ff == mtep_pkg::META_MTC_OFFSET) begin
                        running_status_in = 8'd0;
                     end
                     res.kind          = (phase_ff == mtep_pkg::PH_META_LEN) ?
                                         mtep_pkg::KIND_META : mtep_pkg::KIND_SYSEX;
                     res.status_byte   = current_type_ff;
                     res.last_of_event = (len == '0);
                     remaining_in      = len;
                     phase_in          = (len != '0) ? mtep_pkg::PH_PAYLOAD :
                                                       mtep_pkg::PH_DELTA;
                  end
               end
            end
            mtep_pkg::PH_PAYLOAD: begin
               res_valid         = 1'b1;
               res.kind          = mtep_pkg::KIND_PAYLOAD;
               res.status_byte   = current_type_ff;
               res.data_one      = b;
               res.last_of_event = (remaining_ff <= mtep_pkg::LEN_W'(1));
               if (remaining_ff <= mtep_pkg::LEN_W'(1)) begin
                  remaining_in = '0;
                  phase_in     = mtep_pkg::PH_DELTA;
               end else begin
                  remaining_in = remaining_ff - mtep_pkg::LEN_W'(1);
               end
            end
            default: begin
               // delta time: accumulate seven bits a byte, add on the last one
               if (varlen_end) begin
                  clock_in  = clock_ff + acc;
                  varlen_in = '0;
                  phase_in  = mtep_pkg::PH_STATUS;
               end else begin
                  varlen_in = acc;
                  phase_in  = mtep_pkg::PH_DELTA;
               end
            end
         endcase
      end

      // rewind at chunk end, after the byte is handled
      if (item.chunk_last) begin
         phase_in          = mtep_pkg::PH_DELTA;
         running_status_in = 8'd0;
         clock_in          = '0;
         varlen_in         = '0;
         remaining_in      = '0;
         current_type_in   = 8'd0;
         held_data_in      = 8'd0;
         done_in           = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= mtep_pkg::PH_DELTA;
         running_status_ff <= 8'd0;
         clock_ff          <= '0;
         varlen_ff         <= '0;
         remaining_ff      <= '0;
         current_type_ff   <= 8'd0;
         held_data_ff      <= 8'd0;
         done_ff           <= 1'b0;
      end else if (fire) begin
         phase_ff          <= phase_in;
         running_status_ff <= running_status_in;
         clock_ff          <= clock_in;
         varlen_ff         <= varlen_in;
         remaining_ff      <= remaining_in;
         current_type_ff   <= current_type_in;
         held_data_ff      <= held_data_in;
         done_ff           <= done_in;
      end
   end

endmodule

// ----- rtl/mtep_out_reg.sv -----
// ----------------------------------------------------------------------------
// Result register
// Holds one result word until the response side takes it.
// ----------------------------------------------------------------------------
module mtep_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  mtep_pkg::result_type load_res,
   input  logic                 taken,
   output logic                 free,
   output logic                 hold_valid,
   output mtep_pkg::result_type hold_res
);

   logic                 valid_ff, valid_in;
   mtep_pkg::result_type res_ff;

   assign free = ~valid_ff | taken;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (taken) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= load_res;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_res   = res_ff;

endmodule

// ----- rtl/midi_track_event_parser.sv -----
// ----------------------------------------------------------------------------
// MIDI track event parser
// Decodes standard MIDI file track-chunk bytes into timed event results.
// ----------------------------------------------------------------------------
//  channel   dir  words                              handshake
//  req_chan  in   track_byte, chunk_last             valid/ready
//  rsp_chan  out  kind, event_time, status_byte,     valid/ready
//                 data_one, data_two, payload_length,
//                 last_of_event
//
//  One byte a cycle while the result register is free: an input register
//  feeds the phase update, whose result lands in the result register.
//  A byte that gives no result still passes through the decoder.
//  Reset is synchronous and clears the parse state and both valid flags.
//  While the result register is full and not taken, the decoder holds its byte
//  and the input side stalls once its register is also full.
// ----------------------------------------------------------------------------
module midi_track_event_parser (
   input  logic  clock,
   input  logic  reset,
   mtep_req_if.sink   req_chan,
   mtep_rsp_if.source rsp_chan
);

   mtep_pkg::item_type   req_item;
   mtep_pkg::item_type   hold_item;
   mtep_pkg::result_type step_res;
   mtep_pkg::result_type out_res;
   logic                 hold_valid;
   logic                 step_valid;
   logic                 out_free;
   logic                 advance;
   logic                 req_fire;

   assign advance  = hold_valid & out_free;
   assign req_chan.ready = ~hold_valid | advance;
   assign req_fire = req_chan.valid & req_chan.ready;

   assign req_item.track_byte = req_chan.track_byte;
   assign req_item.chunk_last = req_chan.chunk_last;

   mtep_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (req_fire),
      .load_item  (req_item),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_item  (hold_item)
   );

   mtep_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (hold_item),
      .res_valid (step_valid),
      .res       (step_res)
   );

   mtep_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance & step_valid),
      .load_res   (step_res),
      .taken      (rsp_chan.ready),
      .free       (out_free),
      .hold_valid (rsp_chan.valid),
      .hold_res   (out_res)
   );

   assign rsp_chan.kind           = out_res.kind;
   assign rsp_chan.event_time     = out_res.event_time;
   assign rsp_chan.status_byte    = out_res.status_byte;
   assign rsp_chan.data_one       = out_res.data_one;
   assign rsp_chan.data_two       = out_res.data_two;
   assign rsp_chan.payload_length = out_res.payload_length;
   assign rsp_chan.last_of_event  = out_res.last_of_event;

endmodule

// ----- sim/mtep_event_checker.sv -----
// ----------------------------------------------------------------------------
// Track event parser checker
// Watches both channels of the parser, predicts the event results from each
// accepted byte and compares every accepted result, field by field, with the
// oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module mtep_event_checker
   import mtep_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mtep_req_if  req_mon,
   mtep_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_count
);

   localparam logic [3:0] HIGH_POLY_PRESSURE = 4'hA;
   localparam logic [3:0] HIGH_CONTROL       = 4'hB;
   localparam logic [3:0] HIGH_PROGRAM       = 4'hC;
   localparam logic [3:0] HIGH_CHAN_PRESSURE = 4'hD;
   localparam logic [3:0] HIGH_PITCH_BEND    = 4'hE;

   result_type        due_results[$];
   result_type        want_res;

   phase_type         parse_ph;
   logic [7:0]        run_status;
   logic [7:0]        cur_type;
   logic [7:0]        held_byte;
   logic [TIME_W-1:0] abs_clock;
   logic [31:0]       vl_acc;
   logic [LEN_W-1:0]  remaining;
   logic              track_halted;

   function automatic int data_bytes(input logic [7:0] st);
      case (st[7:4])
         HIGH_KEY_OFF, HIGH_KEY_ON, HIGH_POLY_PRESSURE, HIGH_CONTROL,
         HIGH_PITCH_BEND: return 2;
         HIGH_PROGRAM, HIGH_CHAN_PRESSURE: return 1;
         default: return 0;
      endcase
   endfunction

   task automatic clear_parse();
      parse_ph     = PH_DELTA;
      run_status   = '0;
      cur_type     = '0;
      held_byte    = '0;
      abs_clock    = '0;
      vl_acc       = '0;
      remaining    = '0;
      track_halted = 1'b0;
   endtask

   task automatic post_event(input logic [2:0] kind, input logic [7:0] st,
                             input logic [7:0] d1, input logic [7:0] d2,
                             input logic [LEN_W-1:0] len, input logic fin);
      due_results.push_back(result_type'{kind: kind, event_time: abs_clock,
                                         status_byte: st, data_one: d1, data_two: d2,
                                         payload_length: len, last_of_event: fin});
   endtask

   task automatic halt_track();
      post_event(KIND_ERROR, run_status, '0, '0, '0, 1'b1);
      track_halted = 1'b1;
      parse_ph     = PH_DELTA;
   endtask

   task automatic take_first(input logic [7:0] b);
      int nd;
      nd = data_bytes(run_status);
      if (nd == 0) begin
         halt_track();
      end else begin
         held_byte = b;
         if (nd == 1) begin
            post_event(KIND_CHANNEL, run_status, b, '0, '0, 1'b1);
            parse_ph = PH_DELTA;
         end else begin
            parse_ph = PH_DATA2;
         end
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic last);
      logic [7:0]       st;
      logic [LEN_W-1:0] len;
      logic             meta;
      if (!track_halted) begin
         case (parse_ph)
            PH_STATUS: begin
               if (b == STATUS_SYSEX) begin
                  cur_type = b;
                  vl_acc   = '0;
                  parse_ph = PH_SYSEX_LEN;
               end else if (b == STATUS_META) begin
                  parse_ph = PH_META_TYPE;
               end else if (b[7]) begin
                  run_status = b;
                  if (data_bytes(b) == 0) halt_track();
                  else parse_ph = PH_DATA1;
               end else begin
                  // running status: the word is already the first data byte
                  take_first(b);
               end
            end
            PH_DATA1: take_first(b);
            PH_DATA2: begin
               st = run_status;
               if (st[7:4] == HIGH_KEY_ON && b == 8'h00) st = {HIGH_KEY_OFF, st[3:0]};
               post_event(KIND_CHANNEL, st, held_byte, b, '0, 1'b1);
               parse_ph = PH_DELTA;
            end
            PH_META_TYPE: begin
               cur_type = b;
               vl_acc   = '0;
               parse_ph = PH_META_LEN;
            end
            PH_SYSEX_LEN, PH_META_LEN: begin
               vl_acc = {vl_acc[24:0], b[6:0]};
               if (!b[7]) begin
                  len    = vl_acc[LEN_W-1:0];
                  meta   = (parse_ph == PH_META_LEN);
                  vl_acc = '0;
                  if (meta && cur_type == META_END_OF_TRACK) begin
                     post_event(KIND_END, META_END_OF_TRACK, '0, '0, len, 1'b1);
                     track_halted = 1'b1;
                     parse_ph     = PH_DELTA;
                  end else begin
                     if (meta && cur_type == META_MTC_OFFSET) run_status = '0;
                     post_event(meta ? KIND_META : KIND_SYSEX, cur_type, '0, '0, len,
                                len == '0);
                     remaining = len;
                     parse_ph  = (len != '0) ? PH_PAYLOAD : PH_DELTA;
                  end
               end
            end
            PH_PAYLOAD: begin
               post_event(KIND_PAYLOAD, cur_type, b, '0, '0, remaining <= 1);
               if (remaining <= 1) begin
                  remaining = '0;
                  parse_ph  = PH_DELTA;
               end else begin
                  remaining = remaining - 1'b1;
               end
            end
            default: begin
               // delta time: advance the clock once the quantity closes
               vl_acc = {vl_acc[24:0], b[6:0]};
               if (!b[7]) begin
                  abs_clock = abs_clock + vl_acc;
                  vl_acc    = '0;
                  parse_ph  = PH_STATUS;
               end
            end
         endcase
      end
      if (last) clear_parse();
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parse();
         due_results.delete();
         fail_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            decode_byte(req_mon.track_byte, req_mon.chunk_last);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_results.size() == 0) begin
               $error("result with none outstanding: kind %0d status 0x%0h",
                      rsp_mon.kind, rsp_mon.status_byte);
               fail_count++;
            end else begin
               want_res = due_results.pop_front();
               check_field("kind", 32'(want_res.kind), 32'(rsp_mon.kind));
               check_field("event_time", want_res.event_time, rsp_mon.event_time);
               check_field("status_byte", 32'(want_res.status_byte),
                           32'(rsp_mon.status_byte));
               check_field("data_one", 32'(want_res.data_one), 32'(rsp_mon.data_one));
               check_field("data_two", 32'(want_res.data_two), 32'(rsp_mon.data_two));
               check_field("payload_length", 32'(want_res.payload_length),
                           32'(rsp_mon.payload_length));
               check_field("last_of_event", 32'(want_res.last_of_event),
                           32'(rsp_mon.last_of_event));
            end
         end
      end
      pending_count = due_results.size();
   end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Track event parser testbench
// Feeds the parser a short directed set of chunks and then random track
// chunks, mostly well formed with random content plus noise and cut-off
// events, with random idle bursts on both channels. The checker predicts and
// compares; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import mtep_pkg::*;

   localparam int         RESET_CYCLES   = 7;
   localparam int         ITEM_TARGET    = 750;
   localparam int         CALM_TAIL      = 100;
   localparam int         DRAIN_CYCLES   = 16;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam logic [7:0] ESCAPE_SYSEX   = 8'hF7;

   logic       clock = 1'b0;
   logic       reset;
   int         fail_count;
   int         pending_count;
   int         quiet_cycles;
   bit         calm = 1'b0;
   logic [7:0] gen_status;
   item_type   track_words[$];

   mtep_req_if req_chan ();
   mtep_rsp_if rsp_chan ();

   midi_track_event_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   mtep_event_checker chk (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pick_pct();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 20;
         default: return 60;
      endcase
   endfunction

   function automatic logic [7:0] data_value();
      return ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
   endfunction

   task automatic put_byte(input logic [7:0] b);
      track_words.push_back(item_type'{track_byte: b, chunk_last: 1'b0});
   endtask

   task automatic end_chunk();
      track_words[$].chunk_last = 1'b1;
   endtask

   // pad adds leading continuation words ahead of the quantity's own words
   task automatic put_varlen(input logic [31:0] v, input int pad);
      logic [34:0] w;
      int          n;
      w = 35'(v);
      n = 1;
      while (n < 5 && (w >> (7 * n)) != 0) n++;
      repeat (pad) put_byte({1'b1, 7'($urandom)});
      for (int i = n - 1; i >= 0; i--) put_byte({i != 0, w[7 * i +: 7]});
   endtask

   task automatic put_delta();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 45) put_varlen(0, 0);
      else if (sel < 80) put_varlen($urandom_range(1, 127), 0);
      else if (sel < 93) put_varlen($urandom_range(128, 16383), 0);
      else if (sel < 98) put_varlen($urandom_range(16384, 32'h0FFF_FFFF), 0);
      else put_varlen($urandom, $urandom_range(0, 1));
   endtask

   task automatic put_channel();
      if (gen_status == '0 || $urandom_range(0, 2) == 0) begin
         gen_status = ($urandom_range(0, 3) == 0) ? {HIGH_KEY_ON, 4'($urandom)}
                                                  : {4'($urandom_range(8, 14)), 4'($urandom)};
         put_byte(gen_status);
      end
      put_byte(data_value());
      // program change and channel pressure carry a single data word
      if (gen_status[7:5] != 3'b110)
         put_byte((gen_status[7:4] == HIGH_KEY_ON && $urandom_range(0, 3) == 0)
                  ? 8'h00 : data_value());
   endtask

   task automatic put_blob(input bit is_meta, input logic [7:0] meta_kind, output bit cut);
      logic [31:0] len;
      int          sel;
      int          shown;
      bit          padded;
      sel    = $urandom_range(0, 99);
      padded = ($urandom_range(0, 19) == 0);
      if (sel < 65) len = $urandom_range(0, 6);
      else if (sel < 90) len = $urandom_range(7, 40);
      else len = $urandom_range(41, 32'h0FFF_FFFF);
      put_byte(is_meta ? STATUS_META : STATUS_SYSEX);
      if (is_meta) begin
         put_byte(meta_kind);
         if (meta_kind == META_MTC_OFFSET) gen_status = '0;
      end
      put_varlen(len, padded ? $urandom_range(1, 2) : 0);
      // long or padded lengths: send a few payload words and cut the chunk
      cut   = padded || len > 40;
      shown = cut ? $urandom_range(0, 12) : int'(len);
      repeat (shown) put_byte(8'($urandom));
   endtask

   task automatic build_chunk();
      int         events;
      int         sel;
      bit         cut;
      logic [7:0] mk;
      gen_status = '0;
      cut        = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 24)) put_byte(8'($urandom));
      end else begin
         events = $urandom_range(2, 20);
         while (events > 0 && !cut) begin
            events--;
            put_delta();
            sel = $urandom_range(0, 99);
            if (sel < 58) begin
               put_channel();
            end else if (sel < 70) begin
               put_blob(1'b0, STATUS_SYSEX, cut);
            end else if (sel < 86) begin
               case ($urandom_range(0, 5))
                  0: mk = META_MTC_OFFSET;
                  1: mk = 8'($urandom);
                  default: mk = 8'($urandom_range(0, 127));
               endcase
               if (mk == META_END_OF_TRACK) mk = META_MTC_OFFSET;
               put_blob(1'b1, mk, cut);
            end else if (sel < 91) begin
               put_byte(STATUS_META);
               put_byte(META_END_OF_TRACK);
               put_varlen(($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : 0, 0);
               repeat ($urandom_range(0, 4)) put_byte(8'($urandom));
               cut = 1'b1;
            end else if (sel < 95) begin
               put_byte(8'($urandom_range(8'hF1, 8'hFE)));
               repeat ($urandom_range(0, 4)) put_byte(8'($urandom));
               cut = 1'b1;
            end else begin
               put_byte(8'($urandom));
            end
         end
         if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
      end
      end_chunk();
   endtask

   task automatic build_directed();
      // data word with no running status
      put_varlen(0, 0);
      put_byte(8'h40);
      end_chunk();
      // longest four-word delta, key-on at velocity zero, running status with
      // extreme data words, empty sysex, then an MTC offset clearing the status
      put_varlen(32'h0FFF_FFFF, 0);
      put_byte({HIGH_KEY_ON, 4'hF});
      put_byte(8'h7F);
      put_byte(8'h00);
      put_varlen(0, 0);
      put_byte(8'h00);
      put_byte(8'hFF);
      put_varlen(0, 0);
      put_byte(STATUS_SYSEX);
      put_byte(8'h00);
      put_varlen(0, 0);
      put_byte(STATUS_META);
      put_byte(META_MTC_OFFSET);
      put_byte(8'h01);
      put_byte(8'hAA);
      put_varlen(0, 0);
      put_byte(8'h30);
      end_chunk();
      // escape sysex as a status word
      put_varlen(0, 0);
      put_byte(ESCAPE_SYSEX);
      end_chunk();
      // end of track followed by a word to be dropped
      put_varlen(5, 0);
      put_byte(STATUS_META);
      put_byte(META_END_OF_TRACK);
      put_byte(8'h00);
      put_byte(8'h55);
      end_chunk();
   endtask

   // request side: stimulus and the verdict
   initial begin
      int gap_pct;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.track_byte <= '0;
      req_chan.chunk_last <= 1'b0;
      build_directed();
      while (track_words.size() < ITEM_TARGET) build_chunk();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      for (int k = 0; k < track_words.size(); k++) begin
         if (k % 64 == 0) gap_pct = pick_pct();
         if (track_words.size() - k <= CALM_TAIL) calm = 1'b1;
         if (!calm && $urandom_range(0, 99) < gap_pct) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         req_chan.valid      <= 1'b1;
         req_chan.track_byte <= track_words[k].track_byte;
         req_chan.chunk_last <= track_words[k].chunk_last;
         @(posedge clock);
         while (!req_chan.ready) @(posedge clock);
      end
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // result side: stall in bursts, none in the closing stretch
   initial begin
      int stall_pct;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall_pct = pick_pct();
         repeat (40) begin
            if (!calm && $urandom_range(0, 99) < stall_pct) begin
               rsp_chan.ready <= 1'b0;
               repeat ($urandom_range(1, 7)) @(posedge clock);
            end
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
